>>> hw/rtl/uart_buffered_byte_queues_defines.svh
// ----------------------------------------------------------------------------
// uart buffered byte queues - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef UART_BUFFERED_BYTE_QUEUES_DEFINES_SVH
`define UART_BUFFERED_BYTE_QUEUES_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define UBBQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubbq port check failed");

// next-cycle implication, held off while reset is low
`define UBBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubbq port check failed");

`endif

>>> hw/rtl/ubbq_pkg.sv
// ----------------------------------------------------------------------------
// ubbq_pkg
// Types and constants shared by the buffered byte queue block.
// ----------------------------------------------------------------------------
package ubbq_pkg;

    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int WAIT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT    = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CRLF      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MODE = 2'd2;

    // echo newline modes
    localparam logic [1:0] ECHO_PLAIN  = 2'd0;
    localparam logic [1:0] ECHO_ADD_CR = 2'd1;
    localparam logic [1:0] ECHO_ADD_LF = 2'd2;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } t_ring_ctl;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic              two_free;
        logic [WAIT_W-1:0] level;
    } t_ring_sts;

endpackage

>>> hw/rtl/ubbq_in_if.sv
// ----------------------------------------------------------------------------
// ubbq_in_if
// Command channel: one command code and one data byte per transfer.
// ----------------------------------------------------------------------------
interface ubbq_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] byte_in;

    modport source (output valid, output cmd, output byte_in, input ready);
    modport sink   (input valid, input cmd, input byte_in, output ready);
endinterface

>>> hw/rtl/ubbq_out_if.sv
// ----------------------------------------------------------------------------
// ubbq_out_if
// Result channel: one result per command.
// ----------------------------------------------------------------------------
interface ubbq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       line_valid;
    logic [7:0] line_byte;
    logic [5:0] rx_waiting;
    logic       tx_irq_on;
    logic       echo_lost;

    modport source (
        output valid, output status, output read_byte, output line_valid,
        output line_byte, output rx_waiting, output tx_irq_on, output echo_lost,
        input ready
    );
    modport sink (
        input valid, input status, input read_byte, input line_valid,
        input line_byte, input rx_waiting, input tx_irq_on, input echo_lost,
        output ready
    );
endinterface

>>> hw/rtl/ubbq_ring.sv
// ----------------------------------------------------------------------------
// ubbq_ring
// Byte ring with one slot kept empty, synchronous memory, registered read.
// ----------------------------------------------------------------------------
module ubbq_ring #(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ubbq_pkg::t_ring_ctl  i_ctl,
    output ubbq_pkg::t_ring_sts  o_sts,
    output logic [7:0]           o_rdata
);
    import ubbq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W-1:0]  n_wp;
    logic [PTR_W-1:0]  n_rp;
    logic [PTR_W:0]    used;
    logic [9:0]        used_ext;
    logic              full;
    logic              empty;

    assign n_wp  = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp  = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign full  = (n_wp == r_rp);
    assign empty = (r_wp == r_rp);

    always_comb begin
        if (r_wp >= r_rp) begin
            used = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            used = (PTR_W+1)'(DEPTH) - ({1'b0, r_rp} - {1'b0, r_wp});
        end
    end

    assign used_ext = 10'(used);

    assign o_sts.full     = full;
    assign o_sts.empty    = empty;
    assign o_sts.two_free = (used_ext + 10'd3) <= 10'(DEPTH);
    assign o_sts.level    = (used_ext > 10'd63) ? 6'd63 : used_ext[WAIT_W-1:0];
    assign o_rdata        = r_rdata;

    // entry written at the slot after the write pointer, read likewise
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !full) begin
            r_mem[n_wp] <= i_ctl.data;
        end
        if (i_ctl.pop && !empty) begin
            r_rdata <= r_mem[n_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_ctl.push && !full) begin
                r_wp <= n_wp;
            end
            if (i_ctl.pop && !empty) begin
                r_rp <= n_rp;
            end
        end
    end

endmodule

>>> hw/rtl/uart_buffered_byte_queues.sv
// ----------------------------------------------------------------------------
// uart_buffered_byte_queues
// Transmit and receive byte rings behind a command/result channel pair.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | transfer on
//  i_in     | in  | cmd, byte_in                              | valid & ready
//  o_out    | out | status, read_byte, line_valid, line_byte, | valid & ready
//           |     | rx_waiting, tx_irq_on, echo_lost          |
//  i_cfg_*  | in  | register index, write data                | i_cfg_we
//
//  one command at a time: a plain write, line byte, count query or any command
//  that finds its ring full or empty goes from exec straight to done; a CR LF
//  write adds a push-LF state, a transmitter-ready pop a tx-wait state, a read
//  that pops a read-wait state, and a read with echo also echo pre, main, post
//  the state sequence comes from one access per cycle on each ring memory, with one
//  registered read and one push into the transmit ring per cycle
//  i_in.ready is high while the sequencer is idle; a held result does not
//  block the next transfer, only the finish of the following command
//  reset is synchronous and clears pointers, flags and config; no clearing pass
// ----------------------------------------------------------------------------
module uart_buffered_byte_queues #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ubbq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ubbq_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    ubbq_in_if.sink                           i_in,
    ubbq_out_if.source                        o_out
);
    import ubbq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_EXEC      = 9'b000000010,
        S_PUSH_LF   = 9'b000000100,
        S_RD_WAIT   = 9'b000001000,
        S_ECHO_PRE  = 9'b000010000,
        S_ECHO_MAIN = 9'b000100000,
        S_ECHO_POST = 9'b001000000,
        S_TX_WAIT   = 9'b010000000,
        S_DONE      = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                r_crlf;
    logic                r_echo_en;
    logic [1:0]          r_echo_mode;

    logic [CMD_W-1:0]    r_cmd;
    logic [BYTE_W-1:0]   r_byte;

    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [BYTE_W-1:0]   r_rd;
    logic [BYTE_W-1:0]   n_rd;
    logic                r_lv;
    logic                n_lv;
    logic [BYTE_W-1:0]   r_lb;
    logic [BYTE_W-1:0]   n_lb;
    logic                r_lost;
    logic                n_lost;
    logic                r_irq;
    logic                n_irq;

    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [BYTE_W-1:0]   r_o_rd;
    logic                r_o_lv;
    logic [BYTE_W-1:0]   r_o_lb;
    logic [WAIT_W-1:0]   r_o_wait;
    logic                r_o_irq;
    logic                r_o_lost;

    logic                in_xfer;
    logic                out_load;

    t_ring_ctl           tx_ctl;
    t_ring_ctl           rx_ctl;
    t_ring_sts           tx_sts;
    t_ring_sts           rx_sts;
    logic [BYTE_W-1:0]   tx_rdata;
    logic [BYTE_W-1:0]   rx_rdata;

    ubbq_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tx_ctl),
        .o_sts   (tx_sts),
        .o_rdata (tx_rdata)
    );

    ubbq_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rx_ctl),
        .o_sts   (rx_sts),
        .o_rdata (rx_rdata)
    );

    assign in_xfer     = i_in.valid && (r_state == S_IDLE);
    assign i_in.ready  = (r_state == S_IDLE);

    assign o_out.valid      = r_o_valid;
    assign o_out.status     = r_o_status;
    assign o_out.read_byte  = r_o_rd;
    assign o_out.line_valid = r_o_lv;
    assign o_out.line_byte  = r_o_lb;
    assign o_out.rx_waiting = r_o_wait;
    assign o_out.tx_irq_on  = r_o_irq;
    assign o_out.echo_lost  = r_o_lost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crlf      <= 1'b0;
            r_echo_en   <= 1'b0;
            r_echo_mode <= ECHO_PLAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CRLF:      r_crlf      <= i_cfg_wdata[0];
                CFG_ECHO_EN:   r_echo_en   <= i_cfg_wdata[0];
                CFG_ECHO_MODE: r_echo_mode <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer: each ring sees at most one push or pop per cycle
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_rd     = r_rd;
        n_lv     = r_lv;
        n_lb     = r_lb;
        n_lost   = r_lost;
        n_irq    = r_irq;
        tx_ctl   = '0;
        rx_ctl   = '0;
        out_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state  = S_EXEC;
                    n_status = ST_OK;
                    n_rd     = '0;
                    n_lv     = 1'b0;
                    n_lb     = '0;
                    n_lost   = 1'b0;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_WRITE: begin
                        if (r_crlf && r_byte == CH_LF) begin
                            // CR LF goes in whole or not at all
                            if (tx_sts.two_free) begin
                                tx_ctl.push = 1'b1;
                                tx_ctl.data = CH_CR;
                                n_irq       = 1'b1;
                                n_state     = S_PUSH_LF;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end else if (tx_sts.full) begin
                            n_status = ST_FULL;
                        end else begin
                            tx_ctl.push = 1'b1;
                            tx_ctl.data = r_byte;
                            n_irq       = 1'b1;
                        end
                    end
                    CMD_READ: begin
                        if (rx_sts.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            rx_ctl.pop = 1'b1;
                            n_state    = S_RD_WAIT;
                        end
                    end
                    CMD_TX_READY: begin
                        if (tx_sts.empty) begin
                            n_irq    = 1'b0;
                            n_status = ST_EMPTY;
                        end else begin
                            tx_ctl.pop = 1'b1;
                            n_lv       = 1'b1;
                            n_state    = S_TX_WAIT;
                        end
                    end
                    CMD_RX_BYTE: begin
                        if (rx_sts.full) begin
                            n_status = ST_FULL;
                        end else begin
                            rx_ctl.push = 1'b1;
                            rx_ctl.data = r_byte;
                        end
                    end
                    CMD_COUNT: ;
                    default: ;
                endcase
            end
            S_PUSH_LF: begin
                tx_ctl.push = 1'b1;
                tx_ctl.data = CH_LF;
                n_state     = S_DONE;
            end
            S_RD_WAIT: begin
                n_rd    = rx_rdata;
                n_state = r_echo_en ? S_ECHO_PRE : S_DONE;
            end
            S_ECHO_PRE: begin
                n_state = S_ECHO_MAIN;
                if (r_echo_mode == ECHO_ADD_CR && r_rd == CH_LF) begin
                    if (tx_sts.full) begin
                        n_lost = 1'b1;
                    end else begin
                        tx_ctl.push = 1'b1;
                        tx_ctl.data = CH_CR;
                        n_irq       = 1'b1;
                    end
                end
            end
            S_ECHO_MAIN: begin
                n_state = S_ECHO_POST;
                if (tx_sts.full) begin
                    n_lost = 1'b1;
                end else begin
                    tx_ctl.push = 1'b1;
                    tx_ctl.data = r_rd;
                    n_irq       = 1'b1;
                end
            end
            S_ECHO_POST: begin
                n_state = S_DONE;
                if (r_echo_mode == ECHO_ADD_LF && r_rd == CH_CR) begin
                    if (tx_sts.full) begin
                        n_lost = 1'b1;
                    end else begin
                        tx_ctl.push = 1'b1;
                        tx_ctl.data = CH_LF;
                        n_irq       = 1'b1;
                    end
                end
            end
            S_TX_WAIT: begin
                n_lb    = tx_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                // wait here while the previous result is still held
                if (!r_o_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_irq     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_irq   <= n_irq;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_in.cmd;
            r_byte <= i_in.byte_in;
        end
        r_status <= n_status;
        r_rd     <= n_rd;
        r_lv     <= n_lv;
        r_lb     <= n_lb;
        r_lost   <= n_lost;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_rd     <= r_rd;
            r_o_lv     <= r_lv;
            r_o_lb     <= r_lb;
            r_o_wait   <= rx_sts.level;
            r_o_irq    <= r_irq;
            r_o_lost   <= r_lost;
        end
    end

endmodule

>>> hw/rtl/ubbq_checker.sv
// ----------------------------------------------------------------------------
// ubbq_checker
// Port-level checks on the buffered byte queue block, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_buffered_byte_queues_defines.svh"

module ubbq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic       i_line_valid,
    input logic       i_tx_irq_on,
    input logic       i_echo_lost
);
    import ubbq_pkg::*;

    // a held result stays offered until taken
    `UBBQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // the sequencer is busy in the cycle after a command transfer
    `UBBQ_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // a byte handed to the line comes from a non-empty ring, so the enable is set
    `UBBQ_ASSERT_NOW(a_line_irq, i_clk, i_rst_n, i_out_valid && i_line_valid, i_tx_irq_on && i_status == ST_OK)

    // lost echo only follows a completed read
    `UBBQ_ASSERT_NOW(a_lost_ok, i_clk, i_rst_n, i_out_valid && i_echo_lost, i_status == ST_OK && !i_line_valid)

endmodule

bind uart_buffered_byte_queues ubbq_checker u_ubbq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_line_valid (o_out.line_valid),
    .i_tx_irq_on  (o_out.tx_irq_on),
    .i_echo_lost  (o_out.echo_lost)
);

>>> dv/tb_uart_buffered_byte_queues.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_buffered_byte_queues
// Directed and random commands into the transmit and receive rings, each
// result predicted from a behavioural copy of both rings and the settings,
// then compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_uart_buffered_byte_queues;
    import ubbq_pkg::*;

    localparam int TX_DEPTH      = 64;
    localparam int RX_DEPTH      = 64;
    localparam int WAIT_MAX      = 63;
    localparam int SETTLE_CYCLES = 10;   // longest command is a read with echo
    localparam int PRINT_MAX     = 40;

    // highest code the command field can carry, unused codes sit above count
    localparam logic [CMD_W-1:0] CMD_LAST = 3'd7;
    // spare newline mode, behaves as plain echo
    localparam logic [1:0] ECHO_SPARE = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   read_byte;
        logic                line_valid;
        logic [BYTE_W-1:0]   line_byte;
        logic [WAIT_W-1:0]   rx_waiting;
        logic                tx_irq_on;
        logic                echo_lost;
    } t_result;

    class byte_queue_scoreboard;
        logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
        logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
        int                tx_head, tx_tail, rx_head, rx_tail;
        bit                irq_en, crlf_on, echo_on;
        logic [1:0]        echo_nl;
        t_result           due_results [$];
        int                errors;

        function new();
            tx_head = 0;
            tx_tail = 0;
            rx_head = 0;
            rx_tail = 0;
            irq_en  = 0;
            crlf_on = 0;
            echo_on = 0;
            echo_nl = ECHO_PLAIN;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CRLF:      crlf_on = val[0];
                CFG_ECHO_EN:   echo_on = val[0];
                CFG_ECHO_MODE: echo_nl = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function bit tx_push(logic [BYTE_W-1:0] b);
            int nxt;
            nxt = (tx_tail + 1) % TX_DEPTH;
            if (nxt == tx_head)
                return 0;
            tx_mem[nxt] = b;
            tx_tail     = nxt;
            irq_en      = 1;
            return 1;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
            t_result r;
            int      nxt, level;
            r = '0;
            case (cmd)
                CMD_WRITE: begin
                    if (crlf_on && b == CH_LF) begin
                        // CR LF goes in whole or not at all
                        if (TX_DEPTH - 1 - (tx_tail + TX_DEPTH - tx_head) % TX_DEPTH >= 2) begin
                            void'(tx_push(CH_CR));
                            void'(tx_push(CH_LF));
                        end else begin
                            r.status = ST_FULL;
                        end
                    end else if (!tx_push(b)) begin
                        r.status = ST_FULL;
                    end
                end
                CMD_READ: begin
                    if (rx_head == rx_tail) begin
                        r.status = ST_EMPTY;
                    end else begin
                        rx_head     = (rx_head + 1) % RX_DEPTH;
                        r.read_byte = rx_mem[rx_head];
                        if (echo_on) begin
                            if (echo_nl == ECHO_ADD_CR && r.read_byte == CH_LF
                                    && !tx_push(CH_CR))
                                r.echo_lost = 1'b1;
                            if (!tx_push(r.read_byte))
                                r.echo_lost = 1'b1;
                            if (echo_nl == ECHO_ADD_LF && r.read_byte == CH_CR
                                    && !tx_push(CH_LF))
                                r.echo_lost = 1'b1;
                        end
                    end
                end
                CMD_TX_READY: begin
                    if (tx_head != tx_tail) begin
                        tx_head      = (tx_head + 1) % TX_DEPTH;
                        r.line_valid = 1'b1;
                        r.line_byte  = tx_mem[tx_head];
                    end else begin
                        irq_en   = 0;
                        r.status = ST_EMPTY;
                    end
                end
                CMD_RX_BYTE: begin
                    nxt = (rx_tail + 1) % RX_DEPTH;
                    if (nxt == rx_head) begin
                        r.status = ST_FULL;
                    end else begin
                        rx_mem[nxt] = b;
                        rx_tail     = nxt;
                    end
                end
                default: ;
            endcase
            level = (rx_tail + RX_DEPTH - rx_head) % RX_DEPTH;
            if (level > WAIT_MAX)
                level = WAIT_MAX;
            r.rx_waiting = level[WAIT_W-1:0];
            r.tx_irq_on  = irq_en;
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] e, logic [BYTE_W-1:0] a);
            if (a !== e) begin
                errors++;
                if (errors <= PRINT_MAX)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            end
        endfunction

        function void check_result(t_result act);
            t_result exp;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= PRINT_MAX)
                    $display("%0t: result with no command outstanding, expected none, actual %h",
                             $time, act);
                return;
            end
            exp = due_results.pop_front();
            compare_field("status", BYTE_W'(exp.status), BYTE_W'(act.status));
            compare_field("read_byte", exp.read_byte, act.read_byte);
            compare_field("line_valid", BYTE_W'(exp.line_valid), BYTE_W'(act.line_valid));
            compare_field("line_byte", exp.line_byte, act.line_byte);
            compare_field("rx_waiting", BYTE_W'(exp.rx_waiting), BYTE_W'(act.rx_waiting));
            compare_field("tx_irq_on", BYTE_W'(exp.tx_irq_on), BYTE_W'(act.tx_irq_on));
            compare_field("echo_lost", BYTE_W'(exp.echo_lost), BYTE_W'(act.echo_lost));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    bit                    no_idle;
    byte_queue_scoreboard  sb;

    ubbq_in_if  in_ch ();
    ubbq_out_if out_ch ();

    uart_buffered_byte_queues #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // newline bytes turn up often enough to hit the CR LF paths
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return CH_LF;
            1:       return CH_CR;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= c;
        in_ch.byte_in <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_command(c, b);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic crlf, input logic echo, input logic [1:0] nl);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_CRLF;
        i_cfg_wdata <= {1'b0, crlf};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_ECHO_EN;
        i_cfg_wdata <= {1'b0, echo};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_ECHO_MODE;
        i_cfg_wdata <= nl;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(CFG_CRLF, {1'b0, crlf});
        sb.set_reg(CFG_ECHO_EN, {1'b0, echo});
        sb.set_reg(CFG_ECHO_MODE, nl);
    endtask

    task automatic new_phase(input logic crlf, input logic echo, input logic [1:0] nl);
        wait_drained();
        apply_settings(crlf, echo, nl);
        no_idle = ($urandom_range(0, 3) == 0);
    endtask

    // weights: write, read, transmitter ready, line byte, count or unused
    task automatic run_phase(input int n, input int ww, input int wr, input int wt,
                             input int wx, input int wq);
        int               total, r;
        logic [CMD_W-1:0] c;
        total = ww + wr + wt + wx + wq;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, total - 1);
            if (r < ww)
                c = CMD_WRITE;
            else if (r < ww + wr)
                c = CMD_READ;
            else if (r < ww + wr + wt)
                c = CMD_TX_READY;
            else if (r < ww + wr + wt + wx)
                c = CMD_RX_BYTE;
            else if ($urandom_range(0, 1) == 0)
                c = CMD_COUNT;
            else
                c = CMD_W'($urandom_range(CMD_COUNT + 1, CMD_LAST));
            send_cmd(c, pick_byte());
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    // result side: check every transfer, stall ready at random
    initial begin
        t_result got;
        int      hold;
        out_ch.ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (out_ch.valid && out_ch.ready) begin
                    got.status     = out_ch.status;
                    got.read_byte  = out_ch.read_byte;
                    got.line_valid = out_ch.line_valid;
                    got.line_byte  = out_ch.line_byte;
                    got.rx_waiting = out_ch.rx_waiting;
                    got.tx_irq_on  = out_ch.tx_irq_on;
                    got.echo_lost  = out_ch.echo_lost;
                    sb.check_result(got);
                end
                if (hold == 0 && out_ch.ready && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
                if (hold > 0) begin
                    hold--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        sb = new();
        no_idle = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_CRLF;
        i_cfg_wdata   <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.cmd     <= CMD_WRITE;
        in_ch.byte_in <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // both rings empty, reset settings
        send_cmd(CMD_TX_READY, 8'h00);
        send_cmd(CMD_READ, 8'h00);
        send_cmd(CMD_COUNT, 8'h5A);
        send_cmd(CMD_W'(CMD_COUNT + 1), 8'hA5);
        send_cmd(CMD_W'(CMD_COUNT + 2), 8'h3C);
        send_cmd(CMD_LAST, 8'hC3);
        send_cmd(CMD_WRITE, 8'h00);
        send_cmd(CMD_WRITE, 8'hFF);
        send_cmd(CMD_WRITE, CH_LF);
        repeat (4) send_cmd(CMD_TX_READY, 8'h00);
        send_cmd(CMD_RX_BYTE, 8'h00);
        send_cmd(CMD_RX_BYTE, 8'hFF);
        send_cmd(CMD_RX_BYTE, CH_LF);
        send_cmd(CMD_RX_BYTE, CH_CR);
        send_cmd(CMD_RX_BYTE, 8'h61);

        // CR LF on send, echo with CR ahead of LF
        new_phase(1'b1, 1'b1, ECHO_ADD_CR);
        send_cmd(CMD_WRITE, CH_LF);
        repeat (3) send_cmd(CMD_READ, 8'h00);

        // echo with LF after CR
        new_phase(1'b0, 1'b1, ECHO_ADD_LF);
        repeat (2) send_cmd(CMD_READ, 8'h00);

        // fill the receive ring past full
        new_phase(1'b0, 1'b0, ECHO_PLAIN);
        run_phase(80, 5, 0, 0, 90, 5);
        // echo until the transmit ring overflows
        new_phase(1'b1, 1'b1, ECHO_ADD_CR);
        run_phase(60, 15, 80, 0, 0, 5);
        // drain the transmit ring to empty
        new_phase(1'b1, 1'b0, ECHO_SPARE);
        run_phase(70, 10, 5, 80, 0, 5);
        new_phase(1'b0, 1'b1, ECHO_ADD_LF);
        run_phase(80, 20, 20, 20, 20, 20);
        // host writes against a nearly full transmit ring
        new_phase(1'b1, 1'b1, ECHO_PLAIN);
        run_phase(80, 80, 5, 0, 10, 5);
        new_phase(1'b0, 1'b0, ECHO_ADD_CR);
        run_phase(70, 0, 45, 45, 0, 10);

        wait_drained();
        if (sb.errors == 0)
            $display("tb_uart_buffered_byte_queues passed");
        else
            $display("tb_uart_buffered_byte_queues failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_uart_buffered_byte_queues failed");
        $finish;
    end

endmodule
